@@ hdl/ris_pkg.sv @@
// Shared types, constants and character-code helpers for the running-index
// substitution cipher. No dependencies.
package ris_pkg;

  localparam int unsigned KeyLen     = 29;
  localparam int unsigned CodeW      = 5;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned KeyWordW   = 60;
  localparam int unsigned KeyWord2W  = 25;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned Word0Ents  = 12;
  localparam int unsigned Word1Ents  = 12;
  localparam int unsigned Word2Ents  = 5;

  localparam logic [CodeW-1:0] CodeLen    = 5'd29;
  localparam logic [CodeW-1:0] CodeComma  = 5'd27;
  localparam logic [CodeW-1:0] CodePeriod = 5'd28;
  localparam logic [CodeW-1:0] CodeSpace  = 5'd29;

  localparam logic [ByteW-1:0] ChA      = 8'h41;
  localparam logic [ByteW-1:0] ChZ      = 8'h5A;
  localparam logic [ByteW-1:0] ChLowA   = 8'h61;
  localparam logic [ByteW-1:0] ChLowZ   = 8'h7A;
  localparam logic [ByteW-1:0] ChComma  = 8'h2C;
  localparam logic [ByteW-1:0] ChPeriod = 8'h2E;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] CaseBit  = 8'h20;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE = 2'd0,
    REG_KEY0 = 2'd1,
    REG_KEY1 = 2'd2,
    REG_KEY2 = 2'd3
  } ris_reg_t;

  localparam logic [KeyWordW-1:0]  Key0Reset = 60'd445092485129178177;
  localparam logic [KeyWordW-1:0]  Key1Reset = 60'd891384676364860877;
  localparam logic [KeyWord2W-1:0] Key2Reset = 25'd31354713;

  typedef struct packed {
    logic                               decrypt;
    logic [KeyLen-1:0][CodeW-1:0]       key;
  } ris_cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [CodeW-1:0] idx;
    logic             coded;
  } ris_res_t;

  // ASCII (already upper case) to code, 0 when not in the alphabet
  function automatic logic [CodeW-1:0] code_of(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] d;
    d = c - ChA;
    if (c >= ChA && c <= ChZ) return d[CodeW-1:0] + 5'd1;
    else if (c == ChComma)    return CodeComma;
    else if (c == ChPeriod)   return CodePeriod;
    else if (c == ChSpace)    return CodeSpace;
    else                      return '0;
  endfunction

  // Code to ASCII, byte 0 for 0, 30 and 31
  function automatic logic [ByteW-1:0] char_of(input logic [CodeW-1:0] k);
    if (k >= 5'd1 && k <= 5'd26) return ChA + {3'd0, k} - 8'd1;
    else if (k == CodeComma)     return ChComma;
    else if (k == CodePeriod)    return ChPeriod;
    else if (k == CodeSpace)     return ChSpace;
    else                         return '0;
  endfunction

endpackage

@@ hdl/ris_cfg.sv @@
// Configuration registers: mode bit and the three packed key words.
// Depends on ris_pkg.
module ris_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [ris_pkg::CfgIdxW-1:0] wr_index,
  input  logic [ris_pkg::KeyWordW-1:0] wr_data,
  output ris_pkg::ris_cfg_t           cfg
);
  import ris_pkg::*;

  logic                 mode;
  logic [KeyWordW-1:0]  key_word0;
  logic [KeyWordW-1:0]  key_word1;
  logic [KeyWord2W-1:0] key_word2;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      key_word0 <= Key0Reset;
      key_word1 <= Key1Reset;
      key_word2 <= Key2Reset;
    end else if (wr_en) begin
      unique case (ris_reg_t'(wr_index))
        REG_MODE: mode      <= wr_data[0];
        REG_KEY0: key_word0 <= wr_data;
        REG_KEY1: key_word1 <= wr_data;
        REG_KEY2: key_word2 <= wr_data[KeyWord2W-1:0];
        default:  mode      <= mode;
      endcase
    end
  end

  // unpack five-bit entries
  always_comb begin
    cfg.decrypt = mode;
    for (int i = 0; i < Word0Ents; i++)
      cfg.key[i] = key_word0[CodeW*i +: CodeW];
    for (int i = 0; i < Word1Ents; i++)
      cfg.key[Word0Ents+i] = key_word1[CodeW*i +: CodeW];
    for (int i = 0; i < Word2Ents; i++)
      cfg.key[Word0Ents+Word1Ents+i] = key_word2[CodeW*i +: CodeW];
  end

endmodule

@@ hdl/ris_datapath.sv @@
// Single-pass cipher logic: encrypt lookup and decrypt key search for one byte.
// Depends on ris_pkg.
module ris_datapath (
  input  ris_pkg::ris_cfg_t           cfg,
  input  logic [ris_pkg::ByteW-1:0]   in_byte,
  input  logic [ris_pkg::CodeW-1:0]   idx,
  output ris_pkg::ris_res_t           res
);
  import ris_pkg::*;

  logic [ByteW-1:0] upper;
  logic [CodeW-1:0] enc_code;
  logic [CodeW:0]   enc_sum;
  logic [CodeW-1:0] enc_idx;
  logic [KeyLen-1:0] hit_vec;
  logic             found;
  logic [CodeW-1:0] hit_pos;
  logic [CodeW-1:0] dec_code;

  always_comb begin
    upper    = (in_byte >= ChLowA && in_byte <= ChLowZ) ? (in_byte ^ CaseBit) : in_byte;
    enc_code = code_of(upper);
    enc_sum  = {1'b0, idx} + {1'b0, enc_code};
    enc_idx  = (enc_sum >= {1'b0, CodeLen}) ? CodeW'(enc_sum - {1'b0, CodeLen})
                                            : enc_sum[CodeW-1:0];
  end

  always_comb begin
    for (int p = 0; p < KeyLen; p++)
      hit_vec[p] = (char_of(cfg.key[p]) != '0) && (char_of(cfg.key[p]) == in_byte);
  end

  // lowest matching position wins
  always_comb begin
    found   = 1'b0;
    hit_pos = '0;
    for (int p = KeyLen - 1; p >= 0; p--) begin
      if (hit_vec[p]) begin
        found   = 1'b1;
        hit_pos = CodeW'(p);
      end
    end
    if (hit_pos >= idx) dec_code = hit_pos - idx;
    else                dec_code = hit_pos + CodeLen - idx;
    if (dec_code == '0) dec_code = CodeLen;
  end

  always_comb begin
    res.out_byte = in_byte;
    res.idx      = idx;
    res.coded    = 1'b0;
    if (!cfg.decrypt) begin
      if (enc_code != '0) begin
        res.out_byte = char_of(cfg.key[enc_idx]);
        res.idx      = enc_idx;
        res.coded    = 1'b1;
      end
    end else if (found) begin
      res.out_byte = char_of(dec_code);
      res.idx      = hit_pos;
      res.coded    = 1'b1;
    end
  end

endmodule

@@ hdl/running_index_substitution_cipher_core.sv @@
// Top level of the running-index substitution cipher: input register, cipher
// datapath, result register and running index. Depends on ris_pkg, ris_cfg, ris_datapath.

// Byte-stream cipher over A-Z, comma, period and space (codes 1..29), keyed by
// 29 five-bit entries in the configuration registers (mode 0 encrypts, 1
// decrypts). Throughput is one byte per clock unless the output stalls: the
// running-index update (mod-29 add in encrypt, 29-way key compare and position
// difference in decrypt) is combinational, so consecutive bytes never wait on
// each other. An accepted byte is loaded into the input register, passes the
// datapath and its result is loaded into the output register, from which it is
// offered. The input side stalls only when both registers are full and the
// output is stalled. Assert first with the opening byte of each message to
// clear the running index. Configuration writes are always taken (cfg_ready is
// high) and must only be issued with no transfer in flight.
module running_index_substitution_cipher_core (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ris_pkg::ByteW-1:0]    in_byte,
  input  logic                         first,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ris_pkg::ByteW-1:0]    out_byte,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ris_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ris_pkg::KeyWordW-1:0] cfg_data
);
  import ris_pkg::*;

  ris_cfg_t         cfg;
  ris_res_t         res;

  logic             hold_valid;     // input register occupied
  logic [ByteW-1:0] hold_byte;
  logic             hold_first;
  logic [CodeW-1:0] run_idx;        // always 0..28
  logic [CodeW-1:0] idx_eff;
  logic             adv;            // input register moves to output register
  logic             in_take;

  assign cfg_ready = 1'b1;

  ris_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // output register free or being drained this cycle
  assign adv      = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !adv;
  assign in_take  = in_valid && !in_stall;

  // message start clears the index before this byte is handled
  assign idx_eff = hold_first ? '0 : run_idx;

  ris_datapath u_dp (
    .cfg     (cfg),
    .in_byte (hold_byte),
    .idx     (idx_eff),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      run_idx    <= '0;
    end else begin
      if (in_take)     hold_valid <= 1'b1;
      else if (adv)    hold_valid <= 1'b0;
      if (adv)         out_valid  <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (adv)         run_idx    <= res.idx;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_byte  <= in_byte;
      hold_first <= first;
    end
    if (adv) out_byte <= res.out_byte;
  end

  // the running index never leaves the key range
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    run_idx < CodeLen)
    else $error("running index out of range");

  // a byte that is not coded leaves the running index at the value it was handled with
  a_idx_kept: assert property (@(posedge clk) disable iff (rst)
    adv && !res.coded |=> run_idx == $past(idx_eff))
    else $error("running index changed on pass-through byte");

  // a new result only appears after a transfer out of the input register
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(adv))
    else $error("result appeared without a datapath transfer");

  // the input side never stalls while the input register is empty
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid && out_valid && out_stall)
    else $error("input stalled without a full pipeline");

endmodule

@@ sim/running_index_substitution_cipher_core_tb.sv @@
// Self-checking testbench for running_index_substitution_cipher_core: directed and
// random byte streams in both modes, checked against a behavioral model of the cipher.
// Depends on ris_pkg and the core RTL; needs no files or arguments.
module running_index_substitution_cipher_core_tb;
  import ris_pkg::*;

  localparam int   CycleLimit = 200000;  // far above the slowest legal run
  localparam int   IdlePct    = 25;      // idle/stall chance per cycle, in percent
  localparam int   ReportMax  = 10;
  localparam int   DrainWait  = 4;       // drain margin for the core's input and output registers
  localparam int   Phases     = 10;
  localparam int   PhaseBytes = 40;
  localparam logic MODE_ENC   = 1'b0;
  localparam logic MODE_DEC   = 1'b1;

  // entry i sits at bits 5i+4..5i, so the flat vector is {key_word2, key_word1, key_word0}
  typedef logic [KeyLen-1:0][CodeW-1:0] key_vec_t;

  typedef struct packed {
    logic [ByteW-1:0] src;
    logic [ByteW-1:0] want;
  } cipher_rec_t;

  // ---------------------------------------------------------------- DUT signals
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [ByteW-1:0]    in_byte   = '0;
  logic                first     = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ByteW-1:0]    out_byte;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  ris_reg_t            cfg_index = REG_MODE;
  logic [KeyWordW-1:0] cfg_data  = '0;

  // ---------------------------------------------------------------- cipher model
  logic                 decrypt_q = MODE_ENC;
  logic [KeyWordW-1:0]  key_w0    = Key0Reset;
  logic [KeyWordW-1:0]  key_w1    = Key1Reset;
  logic [KeyWord2W-1:0] key_w2    = Key2Reset;
  int unsigned          run_idx   = 0;

  cipher_rec_t cipher_q[$];   // expected output bytes, oldest first
  cipher_rec_t head_rec;
  int          errors  = 0;
  logic        pace_on = 1'b1; // random idling on both channels

  running_index_substitution_cipher_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .first     (first),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("running_index_substitution_cipher_core_tb: errors");
    $finish;
  end

  // Alphabet: A..Z -> 1..26, comma 27, period 28, space 29, everything else 0.
  function automatic logic [CodeW-1:0] sym_code(input logic [ByteW-1:0] c);
    if (c >= ChA && c <= ChZ) return CodeW'(c - ChA + 8'd1);
    if (c == ChComma)         return CodeComma;
    if (c == ChPeriod)        return CodePeriod;
    if (c == ChSpace)         return CodeSpace;
    return '0;
  endfunction

  // Inverse; codes 0, 30 and 31 have no character and map to byte 0.
  function automatic logic [ByteW-1:0] sym_char(input logic [CodeW-1:0] k);
    if (k >= 5'd1 && k <= 5'd26) return ChA + ByteW'(k) - 8'd1;
    if (k == CodeComma)          return ChComma;
    if (k == CodePeriod)         return ChPeriod;
    if (k == CodeSpace)          return ChSpace;
    return '0;
  endfunction

  function automatic logic [CodeW-1:0] key_entry(input int pos);
    key_vec_t kv;
    kv = {key_w2, key_w1, key_w0};
    return kv[pos];
  endfunction

  // One byte through the cipher; advances the running index like the core does.
  function automatic logic [ByteW-1:0] cipher_step(input logic [ByteW-1:0] b, input logic f);
    logic [ByteW-1:0] res;
    logic [ByteW-1:0] up;
    logic [CodeW-1:0] code;
    int               hit;
    int               p;
    int unsigned      diff;
    res = b;
    if (f) run_idx = 0;
    if (decrypt_q == MODE_ENC) begin
      // lower case folds to upper for coding only; 128..255 never fold
      up   = (b >= ChLowA && b <= ChLowZ) ? b - CaseBit : b;
      code = sym_code(up);
      if (code != '0) begin
        run_idx = (run_idx + code) % KeyLen;
        res     = sym_char(key_entry(int'(run_idx)));
      end
    end else begin
      // lowest matching key position wins; entries with no character never match
      hit = -1;
      for (p = 0; p < KeyLen; p++) begin
        if (hit < 0 && sym_char(key_entry(p)) != '0 && sym_char(key_entry(p)) == b) hit = p;
      end
      if (hit >= 0) begin
        diff = (hit + KeyLen - run_idx) % KeyLen;
        if (diff == 0) diff = KeyLen;  // zero step reads as space
        res     = sym_char(CodeW'(diff));
        run_idx = hit;
      end
    end
    return res;
  endfunction

  function automatic void report_error(input string msg);
    errors++;
    if (errors <= ReportMax) $display("MISMATCH: %s", msg);
  endfunction

  // ---------------------------------------------------------------- output side
  // Stall is redrawn on every falling edge; a transfer is checked at the rising edge.
  always @(negedge clk) out_stall = pace_on && ($urandom_range(99) < IdlePct);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (cipher_q.size() == 0) begin
        report_error($sformatf("unexpected out_byte %02h", out_byte));
      end else begin
        head_rec = cipher_q.pop_front();
        if (out_byte !== head_rec.want)
          report_error($sformatf("in_byte %02h: expected %02h, got %02h",
                                 head_rec.src, head_rec.want, out_byte));
      end
    end
  end

  // ---------------------------------------------------------------- input side
  // Entered at a falling edge, returns at a falling edge with valid low.
  task automatic send_char(input logic [ByteW-1:0] b, input logic f);
    cipher_rec_t rec;
    while (pace_on && $urandom_range(99) < IdlePct) begin
      in_valid = 1'b0;
      in_byte  = ByteW'($urandom);
      first    = 1'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    first    = f;
    do @(posedge clk); while (in_stall);
    rec.src  = b;
    rec.want = cipher_step(b, f);
    cipher_q.push_back(rec);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Config writes mirror into the model at the transfer edge.
  task automatic write_reg(input ris_reg_t idx, input logic [KeyWordW-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE: decrypt_q = data[0];
      REG_KEY0: key_w0    = data;
      REG_KEY1: key_w1    = data;
      REG_KEY2: key_w2    = data[KeyWord2W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Upper bits of the short registers carry junk the core must drop.
  task automatic write_mode(input logic m);
    write_reg(REG_MODE, {59'($urandom), m});
  endtask

  task automatic load_key(input key_vec_t k);
    write_reg(REG_KEY0, k[11:0]);
    write_reg(REG_KEY1, k[23:12]);
    write_reg(REG_KEY2, {35'($urandom), k[28:24]});
  endtask

  // Hold the sender until every expected byte is back; config is only touched after this.
  task automatic quiesce();
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic key_vec_t shuffled_key();
    key_vec_t         k;
    int               i;
    int               j;
    logic [CodeW-1:0] t;
    for (i = 0; i < KeyLen; i++) k[i] = CodeW'(i + 1);
    for (i = KeyLen - 1; i > 0; i--) begin
      j    = $urandom_range(i);
      t    = k[i];
      k[i] = k[j];
      k[j] = t;
    end
    return k;
  endfunction

  // Mostly well-formed text for the current mode, with some raw noise bytes.
  function automatic logic [ByteW-1:0] pick_char();
    logic [ByteW-1:0] c;
    if ($urandom_range(99) < 15) return ByteW'($urandom);
    if (decrypt_q == MODE_DEC) begin
      c = sym_char(key_entry($urandom_range(KeyLen - 1)));
      return (c != '0) ? c : ByteW'($urandom);
    end
    c = sym_char(CodeW'($urandom_range(1, KeyLen)));
    if (c >= ChA && c <= ChZ && $urandom_range(2) == 0) c = c | CaseBit;
    return c;
  endfunction

  // ---------------------------------------------------------------- tests
  // Reset config (encrypt, reset key): alphabet edges, case folding, uncoded bytes.
  task automatic test_reset_encrypt();
    send_char(ChA, 1'b1);
    send_char(ChZ, 1'b0);
    send_char(ChLowA, 1'b0);
    send_char(ChLowZ, 1'b0);
    send_char(ChComma, 1'b0);
    send_char(ChPeriod, 1'b0);
    send_char(ChSpace, 1'b1);   // restart mid-stream
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'hE1, 1'b0);     // high-half byte shaped like 'a' must not fold
  endtask

  // Decrypt with the reset key: first/last key positions, a repeat (zero step),
  // unmatched bytes.
  task automatic test_decrypt();
    quiesce();
    write_mode(MODE_DEC);
    send_char(sym_char(key_entry(0)), 1'b1);
    send_char(sym_char(key_entry(KeyLen - 1)), 1'b0);
    send_char(sym_char(key_entry(KeyLen - 1)), 1'b0);
    send_char(ChLowA, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(sym_char(key_entry(14)), 1'b0);
  endtask

  // Key with entries that have no character and a duplicated character.
  task automatic test_key_oddities();
    key_vec_t k;
    int       i;
    for (i = 0; i < KeyLen; i++) k[i] = CodeW'(i);  // entry 0 holds code 0
    k[1] = CodeW'(30);                               // outside the alphabet
    k[2] = CodeW'(31);
    k[4] = k[3];                                     // 'C' twice
    quiesce();
    load_key(k);
    write_mode(MODE_ENC);
    send_char(ChA, 1'b1);      // lands on code 30 -> byte 0
    send_char(ChA, 1'b0);      // lands on code 31
    send_char(ChComma, 1'b0);  // wraps onto code 0
    send_char(ChZ, 1'b0);
    quiesce();
    write_mode(MODE_DEC);
    send_char(ChA + 8'd2, 1'b1);  // lowest of the two 'C' entries
    send_char(ChA + 8'd2, 1'b0);  // same position again
    send_char(8'h00, 1'b0);       // byte 0 matches no entry
    send_char(ChA + 8'd3, 1'b0);
  endtask

  // Random messages over several keys and both modes; one phase runs without idling.
  task automatic test_random_streams();
    key_vec_t k;
    int       ph;
    int       sent;
    int       len;
    int       n;
    logic     f;
    for (ph = 0; ph < Phases; ph++) begin
      quiesce();
      if (ph == 0)                      k = '1;  // every entry code 31
      else if (ph == 1)                 k = '0;
      else if ($urandom_range(3) == 0)  k = key_vec_t'({$urandom, $urandom, $urandom,
                                                        $urandom, $urandom});
      else                              k = shuffled_key();
      load_key(k);
      write_mode((ph % 2 == 1) ? MODE_DEC : MODE_ENC);
      pace_on = (ph != 4);
      sent = 0;
      while (sent < PhaseBytes) begin
        len = $urandom_range(1, 12);
        for (n = 0; n < len && sent < PhaseBytes; n++) begin
          // most messages open with first; a few continue the index or restart mid-way
          f = (n == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
          send_char(pick_char(), f);
          sent++;
        end
      end
    end
    pace_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_encrypt();
    test_decrypt();
    test_key_oddities();
    test_random_streams();
    quiesce();
    errors += cipher_q.size();
    if (errors == 0)
      $display("running_index_substitution_cipher_core_tb: clean");
    else
      $display("running_index_substitution_cipher_core_tb: errors");
    $finish;
  end

endmodule
